// ----- rtl/core/tenths_timer_seven_segment_driver_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tenths timer display driver
// Shared concurrent check forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TENTHS_TIMER_SEVEN_SEGMENT_DRIVER_MACROS_SVH
`define TENTHS_TIMER_SEVEN_SEGMENT_DRIVER_MACROS_SVH

// consequent holds in the same cycle
`define TTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the following cycle
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg
// Constants, types and the digit code table of the tenths timer display driver.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int MS_W     = 32;
  localparam int VAL_W    = 20;
  localparam int TENTHS_W = 14;
  localparam int SEG_W    = 8;
  localparam int SEL_W    = 4;
  localparam int WORD_W   = 16;
  localparam int DIGITS   = 4;
  localparam int IDX_W    = 2;

  localparam logic [VAL_W-1:0] TIMER_LIMIT = 20'd1000000;

  // floor(ms * 4294 / 2^32) is the quotient by one million or one less
  localparam logic [12:0] RECIP_LIMIT = 13'd4294;
  // exact reciprocal for ms below 2^20 divided by 100
  localparam logic [19:0] RECIP_100_MS = 20'd671089;
  localparam int          SHIFT_100_MS = 26;
  // exact reciprocals for tenths below 2^14
  localparam logic [13:0] RECIP_10   = 14'd13108;
  localparam int          SHIFT_10   = 17;
  localparam logic [13:0] RECIP_100  = 14'd10486;
  localparam int          SHIFT_100  = 20;
  localparam logic [14:0] RECIP_1000 = 15'd16778;
  localparam int          SHIFT_1000 = 24;

  localparam logic [SEG_W-1:0] BLANK_CODE = 8'hFF;
  localparam logic [SEG_W-1:0] POINT_MASK = 8'h7F;
  localparam logic [IDX_W-1:0] LAST_FRAME = 2'd3;

  typedef logic [SEG_W-1:0] seg_t;

  typedef struct packed {
    seg_t [DIGITS-1:0] seg;
    logic              changed;
  } frame_item_t;

  function automatic seg_t seg_code(input logic [3:0] digit);
    seg_t code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = BLANK_CODE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tts_reduce.sv -----
// ----------------------------------------------------------------------------
// tts_reduce
// Three-stage reduction of millisecond counts above one million modulo one million.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_reduce
  import tts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [MS_W-1:0]  in_ms,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic [VAL_W-1:0] out_val
);

  logic              a_v_r, b_v_r, c_v_r;
  logic              a_rdy, b_rdy, c_rdy;
  logic [MS_W-1:0]   a_ms_r;
  logic [12:0]       a_q_r;
  logic              a_big_r;
  logic [VAL_W:0]    b_ms_r;
  logic [VAL_W:0]    b_prod_r;
  logic              b_big_r;
  logic [VAL_W-1:0]  c_val_r;

  logic [44:0]       q_prod;
  logic [12:0]       a_q_nxt;
  logic [32:0]       lim_prod;
  logic [VAL_W:0]    rem_raw;
  logic [VAL_W:0]    rem_fix;
  logic [VAL_W-1:0]  c_val_nxt;

  assign c_rdy    = !c_v_r || out_ready;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = a_rdy;

  always_comb begin
    q_prod    = 45'(in_ms) * 45'(RECIP_LIMIT);
    a_q_nxt   = q_prod[44:32];
    lim_prod  = 33'(a_q_r) * 33'(TIMER_LIMIT);
    rem_raw   = b_ms_r - b_prod_r;
    rem_fix   = (rem_raw >= 21'(TIMER_LIMIT)) ? rem_raw - 21'(TIMER_LIMIT) : rem_raw;
    c_val_nxt = b_big_r ? rem_fix[VAL_W-1:0] : b_ms_r[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= in_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_ms_r  <= in_ms;
      a_q_r   <= a_q_nxt;
      a_big_r <= in_ms > 32'(TIMER_LIMIT);
    end
    if (b_rdy && a_v_r) begin
      b_ms_r   <= a_ms_r[VAL_W:0];
      b_prod_r <= lim_prod[VAL_W:0];
      b_big_r  <= a_big_r;
    end
    if (c_rdy && b_v_r) begin
      c_val_r <= c_val_nxt;
    end
  end

  assign out_valid = c_v_r;
  assign out_val   = c_val_r;

endmodule

`default_nettype wire

// ----- rtl/core/tts_decode.sv -----
// ----------------------------------------------------------------------------
// tts_decode
// Tenths, change flag, decimal digits and segment codes in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_decode
  import tts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [VAL_W-1:0] in_val,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      frame_item_t      out_item
);

  logic                d_v_r, e_v_r, f_v_r;
  logic                d_rdy, e_rdy, f_rdy;
  logic [TENTHS_W-1:0] d_t_r;
  logic [TENTHS_W-1:0] e_t_r;
  logic [9:0]          e_q10_r;
  logic [6:0]          e_q100_r;
  logic [3:0]          e_q1000_r;
  logic                e_chg_r;
  logic [TENTHS_W-1:0] prev_tenths_r;
  frame_item_t         f_item_r;

  logic [39:0]         t_prod;
  logic [27:0]         p10;
  logic [27:0]         p100;
  logic [28:0]         p1000;
  logic [3:0]          dig0, dig1, dig2, dig3;
  frame_item_t         f_item_nxt;

  assign f_rdy    = !f_v_r || out_ready;
  assign e_rdy    = !e_v_r || f_rdy;
  assign d_rdy    = !d_v_r || e_rdy;
  assign in_ready = d_rdy;

  always_comb begin
    t_prod = 40'(in_val) * 40'(RECIP_100_MS);
    p10    = 28'(d_t_r) * 28'(RECIP_10);
    p100   = 28'(d_t_r) * 28'(RECIP_100);
    p1000  = 29'(d_t_r) * 29'(RECIP_1000);

    dig0 = 4'(e_t_r - 14'(e_q10_r) * 14'd10);
    dig1 = 4'(e_q10_r - 10'(e_q100_r) * 10'd10);
    dig2 = 4'(e_q100_r - 7'(e_q1000_r) * 7'd10);
    dig3 = (e_q1000_r >= 4'd10) ? e_q1000_r - 4'd10 : e_q1000_r;

    f_item_nxt.changed = e_chg_r;
    f_item_nxt.seg[0]  = seg_code(dig0);
    f_item_nxt.seg[1]  = (e_q10_r == '0) ? BLANK_CODE : (seg_code(dig1) & POINT_MASK);
    f_item_nxt.seg[2]  = (e_q100_r == '0) ? BLANK_CODE : seg_code(dig2);
    f_item_nxt.seg[3]  = (e_q1000_r == '0) ? BLANK_CODE : seg_code(dig3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r         <= 1'b0;
      e_v_r         <= 1'b0;
      f_v_r         <= 1'b0;
      prev_tenths_r <= '0;
    end else begin
      if (d_rdy) d_v_r <= in_valid;
      if (e_rdy) e_v_r <= d_v_r;
      if (f_rdy) f_v_r <= e_v_r;
      if (e_rdy && d_v_r) prev_tenths_r <= d_t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy && in_valid) begin
      d_t_r <= t_prod[SHIFT_100_MS+TENTHS_W-1:SHIFT_100_MS];
    end
    if (e_rdy && d_v_r) begin
      e_t_r     <= d_t_r;
      e_q10_r   <= p10[SHIFT_10+9:SHIFT_10];
      e_q100_r  <= p100[SHIFT_100+6:SHIFT_100];
      e_q1000_r <= p1000[SHIFT_1000+3:SHIFT_1000];
      e_chg_r   <= d_t_r != prev_tenths_r;
    end
    if (f_rdy && e_v_r) begin
      f_item_r <= f_item_nxt;
    end
  end

  assign out_valid = f_v_r;
  assign out_item  = f_item_r;

endmodule

`default_nettype wire

// ----- rtl/core/tts_frame.sv -----
// ----------------------------------------------------------------------------
// tts_frame
// Output register that sends the four digit frames of one word in turn.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tenths_timer_seven_segment_driver_macros.svh"

module tts_frame
  import tts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire frame_item_t       in_item,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [SEG_W-1:0]  out_segments,
  output      logic [SEL_W-1:0]  out_digit_select,
  output      logic [WORD_W-1:0] out_shift_word,
  output      logic              out_changed,
  output      logic              out_last
);

  logic             full_r, full_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  frame_item_t      item_r;
  logic             take_out;
  logic             take_in;
  logic             at_last;

  assign at_last  = idx_r == LAST_FRAME;
  assign take_out = full_r && out_ready;
  assign in_ready = !full_r || (out_ready && at_last);
  assign take_in  = in_valid && in_ready;

  always_comb begin
    full_nxt = full_r;
    idx_nxt  = idx_r;
    if (take_out) begin
      if (at_last) begin
        full_nxt = take_in;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end else if (take_in) begin
      full_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      full_r <= full_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) item_r <= in_item;
  end

  assign out_valid        = full_r;
  assign out_segments     = item_r.seg[idx_r];
  assign out_digit_select = SEL_W'(1) << idx_r;
  assign out_shift_word   = {out_segments, 4'b0000, out_digit_select};
  assign out_changed      = item_r.changed;
  assign out_last         = at_last;

  `TTS_ASSERT_NEXT(a_run_continues, take_out && !at_last, out_valid, "frame run broken off")
  `TTS_ASSERT_NEXT(a_sel_advance, take_out && !at_last, out_digit_select == ($past(out_digit_select) << 1), "digit select did not advance")
  `TTS_ASSERT_NEXT(a_chg_steady, take_out && !at_last, out_changed == $past(out_changed), "change flag moved within a run")
  `TTS_ASSERT_NOW(a_load_on_last, take_in && full_r, out_ready && at_last, "word loaded over a live run")

endmodule

`default_nettype wire

// ----- rtl/core/tenths_timer_seven_segment_driver.sv -----
// ----------------------------------------------------------------------------
// tenths_timer_seven_segment_driver
// Turns a millisecond count into four seven-segment digit frames.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one word, in_elapsed_ms. Counts above
// one million are taken modulo one million, then shown as tenths of a second.
// Output channel out_valid/out_ready carries four frames per word, tenths digit
// first: active-low segments, one-hot digit select, the 16-bit shift word,
// the change flag (same on all four) and out_last on the fourth frame.
// The first frame is valid once the word has passed the six pipeline registers
// (the first loaded on acceptance) and then the output register; the rest follow
// one a cycle while the receiver does not stall. The single output channel sends
// four frames per word; the next word is taken as the last frame leaves, or at
// once while the output register is empty.
// Reset (rst_n low, synchronous) empties every stage and clears the stored
// previous tenths to zero. When the receiver stalls, the current frame holds
// and the pipeline fills behind it, then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module tenths_timer_seven_segment_driver
  import tts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [MS_W-1:0]   in_elapsed_ms,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [SEG_W-1:0]  out_segments,
  output      logic [SEL_W-1:0]  out_digit_select,
  output      logic [WORD_W-1:0] out_shift_word,
  output      logic              out_changed,
  output      logic              out_last
);

  logic             red_valid, red_ready;
  logic [VAL_W-1:0] red_val;
  logic             dec_valid, dec_ready;
  frame_item_t      dec_item;

  tts_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ms     (in_elapsed_ms),
    .out_valid (red_valid),
    .out_ready (red_ready),
    .out_val   (red_val)
  );

  tts_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (red_valid),
    .in_ready  (red_ready),
    .in_val    (red_val),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_item  (dec_item)
  );

  tts_frame u_frame (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (dec_valid),
    .in_ready         (dec_ready),
    .in_item          (dec_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_select (out_digit_select),
    .out_shift_word   (out_shift_word),
    .out_changed      (out_changed),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
